// ===== src/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the tree-coded bit stream decoder.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int KEY_W     = 9;
    localparam int KEY_CNT_W = 4;
    localparam int SYM_W     = 8;
    localparam int STAT_W    = 3;
    localparam int BLOCK_W   = 16;
    localparam int PAD_W     = 4;
    localparam int PAD_LIMIT = 8;

    localparam logic [KEY_W-1:0]   END_KEY        = 9'd256;
    localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST = 16'd4096;

    // result status codes
    localparam logic [STAT_W-1:0] ST_BYTE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_END_OK     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_PAD    = 3'd2;
    localparam logic [STAT_W-1:0] ST_AFTER_END  = 3'd3;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd4;

    typedef struct packed {
        logic in_bit;
        logic last;
    } code_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_size;
    } cfg_t;

endpackage

// ===== src/hts_if.sv =====
// ----------------------------------------------------------------------------
// hts_if
// Valid/ready channels of the decoder: code bits in, results out, config.
// ----------------------------------------------------------------------------
interface hts_code_if;
    logic          valid;
    logic          ready;
    hts_pkg::code_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hts_result_if;
    logic             valid;
    logic             ready;
    hts_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hts_cfg_if;
    logic          valid;
    logic          ready;
    hts_pkg::cfg_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/hts_ram.sv =====
// ----------------------------------------------------------------------------
// hts_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hts_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/huffman_tree_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_core
// Bit-serial decoder for a stream of preorder-coded trees and tree-walk codes.
// ----------------------------------------------------------------------------
// Each code bit is read and then resolved: in the cycle a bit is accepted the
// node store, the child store and the pending-parent stack are read at
// addresses formed from the current walk state; in the next cycle the read
// data is resolved, state registers and memories are written back and any
// result is loaded into the output register. No new bit is taken while one
// is being resolved, as the node store has a registered read. A waiting
// result holds off the next bit until the beat is taken; a beat taken in
// the same cycle the next bit arrives costs no time. The node store needs
// no clearing pass: only nodes of the current tree are ever read. After
// any end or error status the block swallows further bits until reset.
// Block size may be written only while the block is idle.
module huffman_tree_stream_decoder_core #(
    parameter int MAX_LEAVES = 257
) (
    input  logic                clk,
    input  logic                rst_n,
    hts_code_if.sink            code,
    hts_result_if.source        result,
    hts_cfg_if.sink             cfg
);

    localparam int DEPTH  = 2 * MAX_LEAVES - 1;
    localparam int NAW    = $clog2(DEPTH);
    localparam int NW     = $clog2(DEPTH + 1);
    localparam int SW     = $clog2(MAX_LEAVES);
    localparam int SDEPTH = MAX_LEAVES - 1;
    localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int KW     = hts_pkg::KEY_W;

    localparam logic [2:0] PH_FLAG   = 3'd0;
    localparam logic [2:0] PH_KEY    = 3'd1;
    localparam logic [2:0] PH_DECODE = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    logic [2:0]                      phase_reg, phase_next;
    logic [NW-1:0]                   node_count_reg, node_count_next;
    logic [SW-1:0]                   pend_reg, pend_next;
    logic                            zero_slot_reg, zero_slot_next;
    logic [KW-1:0]                   key_reg, key_next;
    logic [hts_pkg::KEY_CNT_W-1:0]   key_cnt_reg, key_cnt_next;
    logic [NAW-1:0]                  cur_reg, cur_next;
    logic [NAW-1:0]                  cur_child1_reg, cur_child1_next;
    logic [NAW-1:0]                  root_child1_reg, root_child1_next;
    logic                            root_leaf_reg, root_leaf_next;
    logic [hts_pkg::BLOCK_W-1:0]     sym_count_reg, sym_count_next;
    logic [hts_pkg::PAD_W-1:0]       pad_count_reg, pad_count_next;
    logic [hts_pkg::BLOCK_W-1:0]     block_size_reg;
    logic                            busy_reg;
    logic                            bit_reg;
    logic                            last_reg;
    logic [NAW-1:0]                  nxt_reg;
    logic                            out_valid_reg, out_valid_next;
    hts_pkg::result_t                out_beat_reg, out_beat_next;

    logic                            in_fire;
    logic [NAW-1:0]                  nxt_addr;
    logic [SW-1:0]                   pend_dec;
    logic [SW-1:0]                   pend_pop;
    logic [SAW-1:0]                  pop_addr;
    logic [NAW-1:0]                  idx;
    logic [NW-1:0]                   node_count_dec;
    logic [KW-1:0]                   key_full;
    logic [hts_pkg::BLOCK_W-1:0]     sym_inc;
    logic [hts_pkg::PAD_W-1:0]       pad_inc;

    logic                            node_we;
    logic [NAW-1:0]                  node_waddr;
    logic [KW:0]                     node_wdata;
    logic [KW:0]                     node_rdata;
    logic                            child_we;
    logic [NAW-1:0]                  child_waddr;
    logic [NAW-1:0]                  child_wdata;
    logic [NAW-1:0]                  child_rdata;
    logic                            stack_we;
    logic [SAW-1:0]                  stack_waddr;
    logic [NAW-1:0]                  stack_wdata;
    logic [NAW-1:0]                  stack_rdata;

    logic                            res_hit;
    logic [hts_pkg::STAT_W-1:0]      res_stat;
    logic [hts_pkg::SYM_W-1:0]       res_sym;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign code.ready   = !busy_reg && (!out_valid_reg || result.ready);
    assign in_fire      = code.valid && code.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_beat_reg;

    // ------------------------------------------------------------------
    // read addresses, formed from state and the incoming bit
    // ------------------------------------------------------------------
    // a single-leaf tree keeps the walk on the root
    assign nxt_addr = root_leaf_reg ? '0
                    : (code.payload.in_bit ? cur_child1_reg : cur_reg + NAW'(1));
    assign pend_dec = pend_reg - SW'(1);
    assign pop_addr = pend_dec[SAW-1:0];

    // first child is always the node right after its parent, so only a
    // pending second-child slot pops the stack
    assign pend_pop = (!zero_slot_reg && pend_reg != '0) ? pend_dec : pend_reg;

    assign idx            = node_count_reg[NAW-1:0];
    assign node_count_dec = node_count_reg - NW'(1);
    assign key_full       = {bit_reg, key_reg[KW-1:1]};
    assign sym_inc        = sym_count_reg + 16'd1;
    assign pad_inc        = pad_count_reg + 4'd1;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    hts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (KW + 1)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (in_fire),
        .raddr (nxt_addr),
        .rdata (node_rdata)
    );

    hts_ram #(
        .DEPTH (DEPTH),
        .WIDTH (NAW)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (in_fire),
        .raddr (nxt_addr),
        .rdata (child_rdata)
    );

    hts_ram #(
        .DEPTH (SDEPTH),
        .WIDTH (NAW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (in_fire),
        .raddr (pop_addr),
        .rdata (stack_rdata)
    );

    // ------------------------------------------------------------------
    // resolve step
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next       = phase_reg;
        node_count_next  = node_count_reg;
        pend_next        = pend_reg;
        zero_slot_next   = zero_slot_reg;
        key_next         = key_reg;
        key_cnt_next     = key_cnt_reg;
        cur_next         = cur_reg;
        cur_child1_next  = cur_child1_reg;
        root_child1_next = root_child1_reg;
        root_leaf_next   = root_leaf_reg;
        sym_count_next   = sym_count_reg;
        pad_count_next   = pad_count_reg;

        node_we     = 1'b0;
        node_waddr  = idx;
        node_wdata  = '0;
        child_we    = 1'b0;
        child_waddr = stack_rdata;
        child_wdata = idx;
        stack_we    = 1'b0;
        stack_waddr = pend_pop[SAW-1:0];
        stack_wdata = idx;

        res_hit  = 1'b0;
        res_stat = hts_pkg::ST_BYTE;
        res_sym  = '0;

        if (busy_reg)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (node_count_reg >= NW'(DEPTH))
                    begin
                        res_hit  = 1'b1;
                        res_stat = hts_pkg::ST_INCOMPLETE;
                    end
                    else
                    begin
                        zero_slot_next = 1'b0;
                        pend_next      = pend_pop;
                        // patch the second child of the popped parent
                        if (!zero_slot_reg && pend_reg != '0)
                        begin
                            child_we = 1'b1;
                            if (stack_rdata == '0)
                            begin
                                root_child1_next = idx;
                            end
                        end
                        if (bit_reg)
                        begin
                            node_count_next = node_count_reg + NW'(1);
                            key_cnt_next    = '0;
                            phase_next      = PH_KEY;
                        end
                        else if (pend_pop >= SW'(MAX_LEAVES - 1))
                        begin
                            res_hit  = 1'b1;
                            res_stat = hts_pkg::ST_INCOMPLETE;
                        end
                        else
                        begin
                            node_we         = 1'b1;
                            stack_we        = 1'b1;
                            pend_next       = pend_pop + SW'(1);
                            zero_slot_next  = 1'b1;
                            node_count_next = node_count_reg + NW'(1);
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next     = key_full;
                    key_cnt_next = key_cnt_reg + 4'd1;
                    if (key_cnt_reg == hts_pkg::KEY_CNT_W'(KW - 1))
                    begin
                        node_we      = 1'b1;
                        node_waddr   = node_count_dec[NAW-1:0];
                        node_wdata   = {1'b1, key_full};
                        key_cnt_next = '0;
                        if (pend_reg == '0 && !zero_slot_reg)
                        begin
                            // tree complete: start the walk at the root
                            cur_next        = '0;
                            cur_child1_next = root_child1_reg;
                            sym_count_next  = '0;
                            root_leaf_next  = (node_count_reg == NW'(1));
                            if (node_count_reg == NW'(1) && key_full == hts_pkg::END_KEY)
                            begin
                                phase_next     = PH_PAD;
                                pad_count_next = '0;
                                if (last_reg)
                                begin
                                    res_hit  = 1'b1;
                                    res_stat = hts_pkg::ST_END_OK;
                                end
                            end
                            else
                            begin
                                phase_next = PH_DECODE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_FLAG;
                        end
                    end
                end
                PH_DECODE:
                begin
                    if (!node_rdata[KW])
                    begin
                        cur_next        = nxt_reg;
                        cur_child1_next = child_rdata;
                    end
                    else
                    begin
                        cur_next        = '0;
                        cur_child1_next = root_child1_reg;
                        if (node_rdata[KW-1:0] == hts_pkg::END_KEY)
                        begin
                            phase_next     = PH_PAD;
                            pad_count_next = '0;
                            if (last_reg)
                            begin
                                res_hit  = 1'b1;
                                res_stat = hts_pkg::ST_END_OK;
                            end
                        end
                        else
                        begin
                            res_hit  = 1'b1;
                            res_stat = hts_pkg::ST_BYTE;
                            res_sym  = node_rdata[hts_pkg::SYM_W-1:0];
                            if (sym_inc >= block_size_reg)
                            begin
                                // block done: read a fresh tree
                                sym_count_next  = '0;
                                phase_next      = PH_FLAG;
                                node_count_next = '0;
                                pend_next       = '0;
                                zero_slot_next  = 1'b0;
                            end
                            else
                            begin
                                sym_count_next = sym_inc;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    if (bit_reg)
                    begin
                        res_hit  = 1'b1;
                        res_stat = hts_pkg::ST_BAD_PAD;
                    end
                    else
                    begin
                        pad_count_next = pad_inc;
                        if (pad_inc >= hts_pkg::PAD_W'(hts_pkg::PAD_LIMIT))
                        begin
                            res_hit  = 1'b1;
                            res_stat = hts_pkg::ST_AFTER_END;
                        end
                        else if (last_reg)
                        begin
                            res_hit  = 1'b1;
                            res_stat = hts_pkg::ST_END_OK;
                        end
                    end
                end
                PH_IDLE:
                begin
                    // drop the beat
                    res_hit = 1'b0;
                end
                default:
                begin
                    res_hit = 1'b0;
                end
            endcase

            // a last bit that does not close the stream cleanly
            if (last_reg && phase_reg != PH_IDLE
                && (!res_hit || res_stat == hts_pkg::ST_BYTE))
            begin
                res_hit  = 1'b1;
                res_stat = hts_pkg::ST_INCOMPLETE;
                res_sym  = '0;
            end
            if (res_hit && res_stat != hts_pkg::ST_BYTE)
            begin
                phase_next = PH_IDLE;
            end
        end

        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (res_hit)
        begin
            out_valid_next       = 1'b1;
            out_beat_next.symbol = res_sym;
            out_beat_next.status = res_stat;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FLAG;
            node_count_reg  <= '0;
            pend_reg        <= '0;
            zero_slot_reg   <= 1'b0;
            key_cnt_reg     <= '0;
            cur_reg         <= '0;
            cur_child1_reg  <= '0;
            root_child1_reg <= '0;
            root_leaf_reg   <= 1'b0;
            sym_count_reg   <= '0;
            pad_count_reg   <= '0;
            block_size_reg  <= hts_pkg::BLOCK_SIZE_RST;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            node_count_reg  <= node_count_next;
            pend_reg        <= pend_next;
            zero_slot_reg   <= zero_slot_next;
            key_cnt_reg     <= key_cnt_next;
            cur_reg         <= cur_next;
            cur_child1_reg  <= cur_child1_next;
            root_child1_reg <= root_child1_next;
            root_leaf_reg   <= root_leaf_next;
            sym_count_reg   <= sym_count_next;
            pad_count_reg   <= pad_count_next;
            busy_reg        <= in_fire;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid)
            begin
                block_size_reg <= cfg.payload.block_size;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        out_beat_reg <= out_beat_next;
        if (in_fire)
        begin
            bit_reg  <= code.payload.in_bit;
            last_reg <= code.payload.last;
            nxt_reg  <= nxt_addr;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_result_follows_bit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("result beat without a resolving bit");

    a_idle_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |=> phase_reg == PH_IDLE)
        else $error("decoder left the idle phase");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= SW'(MAX_LEAVES - 1))
        else $error("pending stack overflow");

    a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pad_count_reg < hts_pkg::PAD_W'(hts_pkg::PAD_LIMIT))
        else $error("padding count past limit");

endmodule
